FILE: design/spea_pkg.sv
package spea_pkg;

    // Field widths of the request, result and configuration channels.
    localparam int OP_W        = 2;
    localparam int RES_W       = 11;
    localparam int POT_W       = 24;
    localparam int STATUS_W    = 3;
    localparam int ENERGY_W    = 40;
    localparam int TOTAL_W     = 48;
    localparam int SPAN_W      = 6;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;

    // Store geometry and span limit.
    localparam int MAX_RESIDUES = 1024;
    localparam int ADDR_W       = $clog2(MAX_RESIDUES);
    localparam int MAX_CUTOFF   = 63;

    // A contribution is at most 4p in magnitude; the divisor is at most cutoff plus one.
    localparam int AMOUNT_W      = POT_W + 3;
    localparam int DIVIDEND_W    = POT_W + 2;
    localparam int DIVISOR_W     = $clog2(MAX_CUTOFF + 2);
    localparam int DIV_STEP_BITS = 2;
    localparam int DIV_CYCLES    = (DIVIDEND_W + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
    localparam int DIV_PAD_W     = DIV_CYCLES * DIV_STEP_BITS;
    localparam int DIV_CNT_W     = $clog2(DIV_CYCLES);

    typedef enum logic [OP_W-1:0] {
        OP_ACCUM = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_IGNORED      = 3'd1,
        ST_OVER_CUTOFF  = 3'd2,
        ST_OUT_OF_RANGE = 3'd3,
        ST_BAD_WINDOW   = 3'd4
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MAX_SPAN      = 2'd0,
        CFG_EXCLUDE_SPAN  = 2'd1,
        CFG_DECAY_ENABLE  = 2'd2,
        CFG_RESIDUE_COUNT = 2'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CHECK,
        S_RD,
        S_DIV,
        S_ADD,
        S_TOT,
        S_CLEAR,
        S_DONE
    } state_t;

    typedef logic signed [ENERGY_W-1:0] energy_t;
    typedef logic signed [TOTAL_W-1:0]  total_t;

    typedef struct packed {
        logic                rd_en;
        logic                wr_en;
        logic [ADDR_W-1:0]   addr;
        energy_t             wr_data;
    } mem_req_t;

endpackage

FILE: design/spea_if.sv
interface spea_req_if import spea_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic [RES_W-1:0]         first_residue;
    logic [RES_W-1:0]         second_residue;
    logic signed [POT_W-1:0]  pair_potential;

    modport source (output valid, op, first_residue, second_residue, pair_potential,
                    input ready);
    modport sink   (input valid, op, first_residue, second_residue, pair_potential,
                    output ready);
endinterface

interface spea_rsp_if import spea_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    energy_t                 residue_energy;
    total_t                  total_energy;

    modport source (output valid, status, residue_energy, total_energy, input ready);
    modport sink   (input valid, status, residue_energy, total_energy, output ready);
endinterface

interface spea_cfg_if import spea_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CFG_INDEX_W-1:0]  index;
    logic [CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/spea_store.sv
module spea_store import spea_pkg::*; (
    input  logic     clk,
    input  mem_req_t mem_req,
    output energy_t  rd_data
);

    energy_t mem [MAX_RESIDUES];
    energy_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            mem[mem_req.addr] <= mem_req.wr_data;
        end
        if (mem_req.rd_en)
        begin
            rd_data_reg <= mem[mem_req.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/spea_div.sv
module spea_div import spea_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    // Restoring division, two quotient bits per cycle. The remainder stays
    // below the divisor, so it needs only the divisor's width.
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIV_PAD_W-1:0]  quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;

    logic [DIV_PAD_W-1:0]  quo_step;
    logic [DIVISOR_W-1:0]  rem_step;

    always_comb
    begin
        logic [DIVISOR_W:0] trial;
        quo_step = quo_reg;
        rem_step = rem_reg;
        for (int i = 0; i < DIV_STEP_BITS; i++)
        begin
            trial    = {rem_step, quo_step[DIV_PAD_W-1]};
            quo_step = {quo_step[DIV_PAD_W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg})
            begin
                trial       = trial - {1'b0, dsr_reg};
                quo_step[0] = 1'b1;
            end
            rem_step = trial[DIVISOR_W-1:0];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = DIV_PAD_W'(dividend);
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = quo_step;
            rem_next = rem_step;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg[DIVIDEND_W-1:0];

endmodule

FILE: design/span_energy_profile_accumulator.sv
// Span energy profile accumulator.
// Requests arrive on req (valid/ready): op, first_residue, second_residue and
// pair_potential. Each request yields exactly one result on rsp (valid/ready):
// status, residue_energy and the running total_energy. Registers are written
// through cfg at any time the block is idle; cfg is always ready.
// The block works on one request at a time. An accumulate walks every residue
// of the span through a read, modify and write of the energy RAM, in the
// states S_RD, S_ADD and S_TOT, with S_DIV between read and write when decay
// is on, where the two bit per cycle divider sets the pace. A read passes
// through a single RAM read, a rejected request goes from the check straight
// to the result, and a clear sweeps the whole RAM.
// After reset the block first zeroes all 1024 entries of the RAM and accepts
// no request during that sweep; configuration writes are taken throughout.
// The result sits in an output register, so a new request is accepted while
// the previous result is still waiting; the new one then holds in its final
// state until the receiver takes the earlier result.
module span_energy_profile_accumulator import spea_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    spea_req_if.sink    req,
    spea_rsp_if.source  rsp,
    spea_cfg_if.sink    cfg
);

    state_t state_reg, state_next;

    // Configuration registers.
    logic [SPAN_W-1:0] max_span_reg;
    logic [SPAN_W-1:0] exclude_span_reg;
    logic              decay_enable_reg;
    logic [RES_W-1:0]  residue_count_reg;

    // Latched request and walk state.
    logic [OP_W-1:0]          op_reg, op_next;
    logic [RES_W-1:0]         a_reg, a_next;
    logic [RES_W-1:0]         b_reg, b_next;
    logic signed [POT_W-1:0]  p_reg, p_next;
    status_t                  status_reg, status_next;
    logic [RES_W-1:0]         c_reg, c_next;
    logic [ADDR_W-1:0]        sweep_reg, sweep_next;
    logic signed [ENERGY_W:0] delta_reg, delta_next;
    total_t                   total_reg, total_next;

    // Output register.
    logic                     out_valid_reg, out_valid_next;
    status_t                  out_status_reg, out_status_next;
    energy_t                  out_energy_reg, out_energy_next;
    total_t                   out_total_reg, out_total_next;

    mem_req_t                 mem_req;
    energy_t                  rd_data;
    logic                     div_start;
    logic                     div_done;
    logic [DIVIDEND_W-1:0]    div_quotient;
    logic [DIVIDEND_W-1:0]    dividend;
    logic [DIVISOR_W-1:0]     divisor;

    status_t                  chk_status;
    logic [RES_W-1:0]         count_used;
    logic [SPAN_W-1:0]        cut_used;
    logic [RES_W-1:0]         sep;
    logic [RES_W-1:0]         c_minus_one;
    logic                     sweep_last;
    logic                     out_free;

    logic signed [AMOUNT_W-1:0] p_ext;
    logic signed [AMOUNT_W-1:0] num4;
    logic signed [AMOUNT_W-1:0] num_mag;
    logic signed [AMOUNT_W-1:0] quot_ext;
    logic signed [AMOUNT_W-1:0] amount;
    logic [RES_W:0]             twice_c;
    logic [RES_W:0]             mid_sum;
    logic [RES_W:0]             mid_dist;
    logic signed [ENERGY_W:0]   entry_sum;
    energy_t                    entry_new;
    logic signed [TOTAL_W:0]    total_sum;
    total_t                     total_sat;

    spea_store u_store (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    spea_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.residue_energy = out_energy_reg;
    assign rsp.total_energy   = out_total_reg;

    assign out_free   = !out_valid_reg || rsp.ready;
    assign sweep_last = (sweep_reg == ADDR_W'(MAX_RESIDUES - 1));

    // Effective limits and request checks, in the order the spec gives them.
    assign count_used = (residue_count_reg > RES_W'(MAX_RESIDUES)) ?
                        RES_W'(MAX_RESIDUES) : residue_count_reg;
    assign cut_used   = (max_span_reg > SPAN_W'(MAX_CUTOFF)) ?
                        SPAN_W'(MAX_CUTOFF) : max_span_reg;
    assign sep        = b_reg - a_reg;

    always_comb
    begin
        chk_status = ST_OK;
        unique case (op_reg)
            OP_ACCUM:
            begin
                if (exclude_span_reg >= cut_used)
                begin
                    chk_status = ST_BAD_WINDOW;
                end
                else if (a_reg == '0 || a_reg > count_used ||
                         b_reg == '0 || b_reg > count_used)
                begin
                    chk_status = ST_OUT_OF_RANGE;
                end
                else if (b_reg <= a_reg)
                begin
                    chk_status = ST_IGNORED;
                end
                else if (sep > {{(RES_W-SPAN_W){1'b0}}, cut_used})
                begin
                    chk_status = ST_OVER_CUTOFF;
                end
                else if (sep <= {{(RES_W-SPAN_W){1'b0}}, exclude_span_reg})
                begin
                    chk_status = ST_IGNORED;
                end
            end
            OP_READ:
            begin
                if (a_reg == '0 || a_reg > count_used)
                begin
                    chk_status = ST_OUT_OF_RANGE;
                end
            end
            OP_CLEAR:
            begin
                chk_status = ST_OK;
            end
            default:
            begin
                chk_status = ST_IGNORED;
            end
        endcase
    end

    // Contribution of one residue. Without decay it is 2p. With decay it is
    // 4p divided by the distance term, truncated toward zero, so the divider
    // works on the magnitude and the sign is put back afterwards.
    assign p_ext    = {{(AMOUNT_W-POT_W){p_reg[POT_W-1]}}, p_reg};
    assign num4     = p_ext <<< 2;
    assign num_mag  = p_reg[POT_W-1] ? -num4 : num4;
    assign dividend = num_mag[DIVIDEND_W-1:0];
    assign quot_ext = {{(AMOUNT_W-DIVIDEND_W){1'b0}}, div_quotient};
    assign amount   = decay_enable_reg ? (p_reg[POT_W-1] ? -quot_ext : quot_ext)
                                       : (p_ext <<< 1);

    // The distance of 2c from first plus second never exceeds the span, so the
    // divisor stays within cutoff plus one.
    assign twice_c  = {c_reg, 1'b0};
    assign mid_sum  = {1'b0, a_reg} + {1'b0, b_reg};
    assign mid_dist = (twice_c >= mid_sum) ? (twice_c - mid_sum) : (mid_sum - twice_c);
    assign divisor  = DIVISOR_W'(mid_dist + 1'b1);

    assign c_minus_one = c_reg - 1'b1;

    // Saturating entry update; the total takes exactly the change applied.
    assign entry_sum = {rd_data[ENERGY_W-1], rd_data} +
                       {{(ENERGY_W+1-AMOUNT_W){amount[AMOUNT_W-1]}}, amount};
    always_comb
    begin
        if (entry_sum[ENERGY_W] != entry_sum[ENERGY_W-1])
        begin
            entry_new = {entry_sum[ENERGY_W], {(ENERGY_W-1){!entry_sum[ENERGY_W]}}};
        end
        else
        begin
            entry_new = entry_sum[ENERGY_W-1:0];
        end
    end

    assign total_sum = {total_reg[TOTAL_W-1], total_reg} +
                       {{(TOTAL_W-ENERGY_W){delta_reg[ENERGY_W]}}, delta_reg};
    always_comb
    begin
        if (total_sum[TOTAL_W] != total_sum[TOTAL_W-1])
        begin
            total_sat = {total_sum[TOTAL_W], {(TOTAL_W-1){!total_sum[TOTAL_W]}}};
        end
        else
        begin
            total_sat = total_sum[TOTAL_W-1:0];
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                priority if (op_reg == OP_CLEAR)
                begin
                    state_next = S_CLEAR;
                end
                else if (chk_status == ST_OK)
                begin
                    state_next = S_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_RD:
            begin
                priority if (op_reg == OP_READ)
                begin
                    state_next = S_DONE;
                end
                else if (decay_enable_reg)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_ADD;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                state_next = S_TOT;
            end
            S_TOT:
            begin
                state_next = (c_reg == b_reg) ? S_DONE : S_RD;
            end
            S_CLEAR:
            begin
                if (sweep_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        op_next         = op_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        p_next          = p_reg;
        status_next     = status_reg;
        c_next          = c_reg;
        sweep_next      = sweep_reg;
        delta_next      = delta_reg;
        total_next      = total_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_energy_next = out_energy_reg;
        out_total_next  = out_total_reg;
        div_start       = 1'b0;
        mem_req.rd_en   = 1'b0;
        mem_req.wr_en   = 1'b0;
        mem_req.addr    = c_minus_one[ADDR_W-1:0];
        mem_req.wr_data = entry_new;

        unique case (state_reg)
            S_INIT, S_CLEAR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.addr    = sweep_reg;
                mem_req.wr_data = '0;
                sweep_next      = sweep_reg + 1'b1;
                if (sweep_last)
                begin
                    total_next = '0;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next = req.op;
                    a_next  = req.first_residue;
                    b_next  = req.second_residue;
                    p_next  = req.pair_potential;
                end
            end
            S_CHECK:
            begin
                status_next = chk_status;
                c_next      = a_reg;
            end
            S_RD:
            begin
                mem_req.rd_en = 1'b1;
                div_start     = (op_reg != OP_READ) && decay_enable_reg;
            end
            S_DIV:
            begin
            end
            S_ADD:
            begin
                mem_req.wr_en = 1'b1;
                delta_next    = {entry_new[ENERGY_W-1], entry_new} -
                                {rd_data[ENERGY_W-1], rd_data};
            end
            S_TOT:
            begin
                total_next = total_sat;
                c_next     = c_reg + 1'b1;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_total_next  = total_reg;
                    out_energy_next = (op_reg == OP_READ && status_reg == ST_OK) ?
                                      rd_data : '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_INIT;
            sweep_reg         <= '0;
            total_reg         <= '0;
            out_valid_reg     <= 1'b0;
            max_span_reg      <= SPAN_W'(10);
            exclude_span_reg  <= SPAN_W'(3);
            decay_enable_reg  <= 1'b0;
            residue_count_reg <= RES_W'(MAX_RESIDUES);
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                unique case (cfg_index_t'(cfg.index))
                    CFG_MAX_SPAN:      max_span_reg      <= cfg.data[SPAN_W-1:0];
                    CFG_EXCLUDE_SPAN:  exclude_span_reg  <= cfg.data[SPAN_W-1:0];
                    CFG_DECAY_ENABLE:  decay_enable_reg  <= cfg.data[0];
                    CFG_RESIDUE_COUNT: residue_count_reg <= cfg.data[RES_W-1:0];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        p_reg          <= p_next;
        status_reg     <= status_next;
        c_reg          <= c_next;
        delta_reg      <= delta_next;
        out_status_reg <= out_status_next;
        out_energy_reg <= out_energy_next;
        out_total_reg  <= out_total_next;
    end

endmodule
